FILE: rtl/prtr_pkg.sv
// prtr_pkg: shared types, constants and tables of the permutation rank/turn/re-rank unit
// no dependencies; used by every module under rtl/
package prtr_pkg;

    localparam int unsigned NUM_ELEMS = 12;
    localparam int unsigned RANK_W    = 29;
    localparam int unsigned MOVE_W    = 4;
    localparam int unsigned ELEM_W    = 4;

    localparam logic [RANK_W-1:0] RANK_LIMIT = 29'd479001600;

    // slot k of a permutation word holds one element number
    typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] t_perm;

    // one rotation of three positions: a takes b, b takes c, c takes a
    typedef struct packed {
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        logic [ELEM_W-1:0] c;
    } t_cyc;

    // beat travelling through the unrank cells
    typedef struct packed {
        logic              bad;
        logic [MOVE_W-1:0] move;
        logic [RANK_W-1:0] rem;
        t_perm             perm;
    } t_unrk;

    // beat travelling through the rank cells
    typedef struct packed {
        logic                 bad;
        t_perm                perm;
        logic [NUM_ELEMS-1:0] used;
        logic [RANK_W-1:0]    total;
    } t_rnk;

    function automatic logic [RANK_W-1:0] fact(input int unsigned n);
        logic [RANK_W-1:0] f;
        case (n)
            0:       f = 29'd1;
            1:       f = 29'd1;
            2:       f = 29'd2;
            3:       f = 29'd6;
            4:       f = 29'd24;
            5:       f = 29'd120;
            6:       f = 29'd720;
            7:       f = 29'd5040;
            8:       f = 29'd40320;
            9:       f = 29'd362880;
            10:      f = 29'd3628800;
            11:      f = 29'd39916800;
            12:      f = 29'd479001600;
            default: f = '0;
        endcase
        return f;
    endfunction

    // moves 8..15 undo moves 0..7
    function automatic t_cyc cyc(input logic [MOVE_W-1:0] m);
        t_cyc r;
        unique case (m)
            4'd0:  r = '{a: 4'd0,  b: 4'd1,  c: 4'd2};
            4'd1:  r = '{a: 4'd0,  b: 4'd4,  c: 4'd3};
            4'd2:  r = '{a: 4'd1,  b: 4'd5,  c: 4'd6};
            4'd3:  r = '{a: 4'd3,  b: 4'd7,  c: 4'd5};
            4'd4:  r = '{a: 4'd2,  b: 4'd9,  c: 4'd8};
            4'd5:  r = '{a: 4'd4,  b: 4'd8,  c: 4'd10};
            4'd6:  r = '{a: 4'd6,  b: 4'd11, c: 4'd9};
            4'd7:  r = '{a: 4'd7,  b: 4'd10, c: 4'd11};
            4'd8:  r = '{a: 4'd2,  b: 4'd1,  c: 4'd0};
            4'd9:  r = '{a: 4'd3,  b: 4'd4,  c: 4'd0};
            4'd10: r = '{a: 4'd6,  b: 4'd5,  c: 4'd1};
            4'd11: r = '{a: 4'd5,  b: 4'd7,  c: 4'd3};
            4'd12: r = '{a: 4'd8,  b: 4'd9,  c: 4'd2};
            4'd13: r = '{a: 4'd10, b: 4'd8,  c: 4'd4};
            4'd14: r = '{a: 4'd9,  b: 4'd11, c: 4'd6};
            4'd15: r = '{a: 4'd11, b: 4'd10, c: 4'd7};
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/perm_rank_turn_rerank_unit.sv
// perm_rank_turn_rerank_unit: top level, unrank chain, move stage, rank chain, output skid
// depends on prtr_pkg, prtr_unrank_cell, prtr_move_stage, prtr_rank_cell
//
// usage
//   slave channel: one beat carries a 29-bit permutation rank and a 4-bit move number
//   master channel: one beat carries the re-ranked permutation after the move and,
//     in tuser, a flag set when the input rank was 12! or more (tdata is then zero)
//   every input beat yields exactly one output beat, in order
// path: an accepted input beat passes 12 unrank cells, 1 move stage, 12 rank cells
//   and 1 output register on its way to m_axis_tvalid
// throughput: one beat per cycle while the skid is empty; the chain moves forward as one,
//   a beat entering each cycle, so the depth of the chain sets latency and not rate
// stall: when the receiver holds tready low, the output register keeps its beat and
//   the next finished beat lands in a one-entry skid register; while the skid is
//   full the whole chain holds and s_axis_tready is low. s_axis_tready comes straight
//   from a register, so there is no combinational path from m_axis_tready
// reset: synchronous, active low; clears all valid bits, the chain comes up empty
//   and s_axis_tready is high in the first cycle after reset
module perm_rank_turn_rerank_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [28:0] perm_rank, [32:29] move_sel, [39:33] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [28:0] new_rank, [31:29] zero
    output logic        m_axis_tuser    // [0] rank_bad
);

    localparam int unsigned N = prtr_pkg::NUM_ELEMS;

    // chain enable: everything advances unless the skid register is full
    logic en;

    // input unpacking
    logic [prtr_pkg::RANK_W-1:0] in_rank;
    logic [prtr_pkg::MOVE_W-1:0] in_move;
    logic                        in_bad;

    // cell chains
    logic            u_vld [N+1];
    prtr_pkg::t_unrk u_dat [N+1];
    logic            k_vld [N+1];
    prtr_pkg::t_rnk  k_dat [N+1];

    // result of the last rank cell
    logic [prtr_pkg::RANK_W-1:0] fin_rank;
    logic                        fin_bad;

    // output register and skid register
    logic                        r_out_vld;
    logic [prtr_pkg::RANK_W-1:0] r_out_rank;
    logic                        r_out_bad;
    logic                        r_skid_vld;
    logic [prtr_pkg::RANK_W-1:0] r_skid_rank;
    logic                        r_skid_bad;
    logic                        take;

    assign en   = !r_skid_vld;
    assign take = r_out_vld && m_axis_tready;

    assign in_rank = s_axis_tdata[28:0];
    assign in_move = s_axis_tdata[32:29];
    assign in_bad  = (in_rank >= prtr_pkg::RANK_LIMIT);

    // first cell sees the full sorted element list; a bad rank is unranked as zero
    always_comb begin
        u_vld[0]      = s_axis_tvalid;
        u_dat[0].bad  = in_bad;
        u_dat[0].move = in_move;
        u_dat[0].rem  = in_bad ? '0 : in_rank;
        for (int k = 0; k < N; k++) begin
            u_dat[0].perm[k] = prtr_pkg::ELEM_W'(k);
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_unrank
        prtr_unrank_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (u_vld[g]),
            .i_data  (u_dat[g]),
            .o_vld   (u_vld[g+1]),
            .o_data  (u_dat[g+1])
        );
    end

    prtr_move_stage u_move (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (u_vld[N]),
        .i_data  (u_dat[N]),
        .o_vld   (k_vld[0]),
        .o_data  (k_dat[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_rank
        prtr_rank_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (k_vld[g]),
            .i_data  (k_dat[g]),
            .o_vld   (k_vld[g+1]),
            .o_data  (k_dat[g+1])
        );
    end

    assign fin_bad  = k_dat[N].bad;
    assign fin_rank = fin_bad ? '0 : k_dat[N].total;

    // output register with one-entry skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            // chain is frozen; drain the skid once the receiver takes a beat
            if (take) begin
                r_out_vld  <= 1'b1;
                r_out_rank <= r_skid_rank;
                r_out_bad  <= r_skid_bad;
                r_skid_vld <= 1'b0;
            end
        end else if (k_vld[N]) begin
            if (!r_out_vld || take) begin
                r_out_vld  <= 1'b1;
                r_out_rank <= fin_rank;
                r_out_bad  <= fin_bad;
            end else begin
                r_skid_vld  <= 1'b1;
                r_skid_rank <= fin_rank;
                r_skid_bad  <= fin_bad;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'd0, r_out_rank};
    assign m_axis_tuser  = r_out_bad;

    // skid only fills behind an occupied output register
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full while output register empty");

    // a finished beat meeting a stalled output must go to the skid
    a_stall_to_skid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && k_vld[N] && r_out_vld && !m_axis_tready) |=> r_skid_vld)
        else $error("finished beat lost on stall");

    // flagged beats carry a zero rank
    a_bad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
        else $error("flagged beat with nonzero rank");

    // a good result is always a valid rank
    a_rank_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[28:0] < prtr_pkg::RANK_LIMIT))
        else $error("result rank out of range");

endmodule

FILE: rtl/prtr_unrank_cell.sv
// prtr_unrank_cell: one factoradic digit of the unrank chain, registered
// depends on prtr_pkg
module prtr_unrank_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  prtr_pkg::t_unrk i_data,
    output logic            o_vld,
    output prtr_pkg::t_unrk o_data
);

    localparam int unsigned NW = prtr_pkg::NUM_ELEMS - 1 - IDX;
    localparam logic [prtr_pkg::RANK_W-1:0] W = prtr_pkg::fact(NW);

    logic [prtr_pkg::ELEM_W-1:0] q;
    logic [prtr_pkg::ELEM_W-1:0] sel;
    prtr_pkg::t_unrk             n_data;
    logic                        r_vld;
    prtr_pkg::t_unrk             r_data;

    always_comb begin
        // digit = how many multiples of the weight fit in the remainder
        q = '0;
        for (int k = 1; k < prtr_pkg::NUM_ELEMS; k++) begin
            if (k <= NW && {4'd0, i_data.rem} >= 33'(k) * {4'd0, W}) begin
                q = q + 4'd1;
            end
        end
        sel = 4'(IDX) + q;
        n_data      = i_data;
        n_data.rem  = i_data.rem - W * {25'd0, q};
        // slots below IDX are placed; the rest is the sorted unused list
        n_data.perm[IDX] = i_data.perm[sel];
        for (int k = 0; k < prtr_pkg::NUM_ELEMS; k++) begin
            if (k > IDX && k <= int'(sel)) begin
                n_data.perm[k] = i_data.perm[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld  <= i_vld;
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

FILE: rtl/prtr_move_stage.sv
// prtr_move_stage: applies the selected rotation of three positions, registered
// depends on prtr_pkg
module prtr_move_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  prtr_pkg::t_unrk i_data,
    output logic            o_vld,
    output prtr_pkg::t_rnk  o_data
);

    prtr_pkg::t_cyc cy;
    prtr_pkg::t_rnk n_data;
    logic           r_vld;
    prtr_pkg::t_rnk r_data;

    always_comb begin
        cy = prtr_pkg::cyc(i_data.move);
        n_data.bad        = i_data.bad;
        n_data.used       = '0;
        n_data.total      = '0;
        n_data.perm       = i_data.perm;
        n_data.perm[cy.a] = i_data.perm[cy.b];
        n_data.perm[cy.b] = i_data.perm[cy.c];
        n_data.perm[cy.c] = i_data.perm[cy.a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld  <= i_vld;
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

FILE: rtl/prtr_rank_cell.sv
// prtr_rank_cell: one Lehmer digit of the re-rank chain, accumulates the rank
// depends on prtr_pkg
module prtr_rank_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  prtr_pkg::t_rnk i_data,
    output logic           o_vld,
    output prtr_pkg::t_rnk o_data
);

    localparam logic [prtr_pkg::RANK_W-1:0] W = prtr_pkg::fact(prtr_pkg::NUM_ELEMS - 1 - IDX);

    logic [prtr_pkg::ELEM_W-1:0] v;
    logic [prtr_pkg::ELEM_W-1:0] cnt;
    prtr_pkg::t_rnk              n_data;
    logic                        r_vld;
    prtr_pkg::t_rnk              r_data;

    always_comb begin
        v   = i_data.perm[IDX];
        // unused elements smaller than this one
        cnt = '0;
        for (int j = 0; j < prtr_pkg::NUM_ELEMS; j++) begin
            if (j < int'(v) && !i_data.used[j]) begin
                cnt = cnt + 4'd1;
            end
        end
        n_data         = i_data;
        n_data.used    = i_data.used | (12'd1 << v);
        n_data.total   = i_data.total + W * {25'd0, cnt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld  <= i_vld;
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule
